/* sv/tdda_pkg.sv */
// Shared types and codes for the two-axis DDA step generator.
// No dependencies; the top level, the result buffer and the testbench import it.
`default_nettype none

package tdda_pkg;

   // Command codes of an input item. Code 3 is not assigned and does nothing.
   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_STOP    = 2'd2
   } cmd_type;

   // Register indexes of the configuration port (byte address is 4 times this).
   localparam logic REG_INVERT_X = 1'b0;
   localparam logic REG_INVERT_Y = 1'b1;

   // One result item.
   typedef struct packed {
      logic accepted;
      logic step_x;
      logic step_y;
      logic dir_x_level;
      logic dir_y_level;
      logic segment_done;
      logic busy_res;
      logic queue_full;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/two_axis_dda_step_generator.sv */
// Top level of the two-axis DDA step generator with a segment queue.
// Depends on tdda_pkg, tdda_queue_mem, tdda_axis and tdda_rsp_buf.
//
//   Channel  Direction  Handshake               Carries
//   req_*    in         req_valid / req_stall   command, segment fields
//   rsp_*    out        rsp_valid / rsp_stall   status and step pulses
//   apb      in/out     psel, penable, pready   invert_x (0x0), invert_y (0x4)
//
// The block takes one item every clock unless stalled. Each accepted item
// updates the whole state in the cycle it is taken, and its result is written
// into a two-entry result buffer at the same edge, so it is offered on the
// result channel in order. The queue entries live in one synchronous memory
// whose registered read always presents the entry at the read pointer. Reset
// is synchronous and clears pointers, the active segment and the pins; queue
// contents are not cleared. req_stall rises only when the result buffer is
// full, so a stalled result channel holds back at most two items.
`default_nettype none

module two_axis_dda_step_generator #(
   parameter int QUEUE_DEPTH = 16,
   parameter int COUNT_BITS  = 24
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [1:0]            req_command,
   input  wire logic [COUNT_BITS-1:0] req_steps_x,
   input  wire logic [COUNT_BITS-1:0] req_steps_y,
   input  wire logic                  req_dir_x,
   input  wire logic                  req_dir_y,
   input  wire logic [COUNT_BITS-1:0] req_segment_ticks,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_accepted,
   output logic                       rsp_step_x,
   output logic                       rsp_step_y,
   output logic                       rsp_dir_x_level,
   output logic                       rsp_dir_y_level,
   output logic                       rsp_segment_done,
   output logic                       rsp_busy_res,
   output logic                       rsp_queue_full,

   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [2:0]            paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   import tdda_pkg::*;

   localparam int CB      = COUNT_BITS;
   localparam int ERR_W   = 2 * COUNT_BITS + 1;
   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int ENTRY_W = 3 * COUNT_BITS + 2;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   // Ring pointer advance; the queue depth need not be a power of two.
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   // Queue pointers and the active segment.
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic             active_ff, active_in;
   logic [CB-1:0]    act_sx_ff, act_sx_in;
   logic [CB-1:0]    act_sy_ff, act_sy_in;
   logic [CB-1:0]    act_dur_ff, act_dur_in;
   logic [1:0]       act_dir_ff, act_dir_in;
   logic [CB-1:0]    elapsed_ff, elapsed_in;
   logic [ERR_W-1:0] err_x_ff, err_x_in;
   logic [ERR_W-1:0] err_y_ff, err_y_in;
   logic             pin_x_ff, pin_x_in;
   logic             pin_y_ff, pin_y_in;
   logic             inv_x_ff;
   logic             inv_y_ff;

   logic             acc;
   logic             buf_full;
   logic             wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] head;
   logic             is_empty;
   logic             is_full;

   // Operands of this tick: the active segment, or the queue head on a pop.
   logic [CB-1:0]    use_sx, use_sy, use_dur;
   logic [1:0]       use_dir;
   logic [CB-1:0]    el_base, elapsed_nx;
   logic [ERR_W-1:0] ex_base, ey_base;
   logic [ERR_W-1:0] ex_next, ey_next;
   logic             hit_x, hit_y;
   logic             done;
   rsp_type          res;
   rsp_type          out_data;
   cmd_type          cmd;

   assign acc       = req_valid && !req_stall;
   assign req_stall = buf_full;
   assign cmd       = cmd_type'(req_command);
   assign is_empty  = (rd_ff == wr_ff);
   assign is_full   = (ptr_next(wr_ff) == rd_ff);
   assign wr_data   = {req_dir_y, req_dir_x, req_segment_ticks, req_steps_y, req_steps_x};

   // Configuration port: always ready, the register index is paddr[2].
   assign pready = 1'b1;
   assign prdata = {31'd0, (paddr[2] == REG_INVERT_Y) ? inv_y_ff : inv_x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff <= 1'b0;
         inv_y_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready) begin
         if (paddr[2] == REG_INVERT_Y) begin
            inv_y_ff <= pwdata[0];
         end else begin
            inv_x_ff <= pwdata[0];
         end
      end
   end

   // When no segment is active, the queue head is loaded and the counter and
   // accumulators start from zero within the same tick.
   always_comb begin
      use_sx  = active_ff ? act_sx_ff  : head[CB-1:0];
      use_sy  = active_ff ? act_sy_ff  : head[2*CB-1:CB];
      use_dur = active_ff ? act_dur_ff : head[3*CB-1:2*CB];
      use_dir = active_ff ? act_dir_ff : head[3*CB+1:3*CB];
      el_base = active_ff ? elapsed_ff : '0;
      ex_base = active_ff ? err_x_ff   : '0;
      ey_base = active_ff ? err_y_ff   : '0;
      elapsed_nx = el_base + 1'b1;
      done       = (elapsed_nx >= use_dur);
   end

   tdda_axis #(.CB(CB), .ERR_W(ERR_W)) u_axis_x (
      .err_base (ex_base),
      .steps    (use_sx),
      .duration (use_dur),
      .err_next (ex_next),
      .step     (hit_x)
   );

   tdda_axis #(.CB(CB), .ERR_W(ERR_W)) u_axis_y (
      .err_base (ey_base),
      .steps    (use_sy),
      .duration (use_dur),
      .err_next (ey_next),
      .step     (hit_y)
   );

   // Next state and the result of the accepted item.
   always_comb begin
      rd_in      = rd_ff;
      wr_in      = wr_ff;
      active_in  = active_ff;
      act_sx_in  = act_sx_ff;
      act_sy_in  = act_sy_ff;
      act_dur_in = act_dur_ff;
      act_dir_in = act_dir_ff;
      elapsed_in = elapsed_ff;
      err_x_in   = err_x_ff;
      err_y_in   = err_y_ff;
      pin_x_in   = pin_x_ff;
      pin_y_in   = pin_y_ff;
      wr_en      = 1'b0;
      res        = '0;
      if (acc) begin
         case (cmd)
            CMD_ENQUEUE: begin
               // A zero duration or a full queue refuses the segment.
               if ((req_segment_ticks != '0) && !is_full) begin
                  wr_en        = 1'b1;
                  wr_in        = ptr_next(wr_ff);
                  res.accepted = 1'b1;
               end
            end
            CMD_TICK: begin
               // A tick with no active segment and an empty queue does nothing.
               if (active_ff || !is_empty) begin
                  if (!active_ff) begin
                     rd_in      = ptr_next(rd_ff);
                     act_sx_in  = use_sx;
                     act_sy_in  = use_sy;
                     act_dur_in = use_dur;
                     act_dir_in = use_dir;
                  end
                  elapsed_in = elapsed_nx;
                  err_x_in   = ex_next;
                  err_y_in   = ey_next;
                  if (hit_x) begin
                     pin_x_in   = use_dir[0] ^ inv_x_ff;
                     res.step_x = 1'b1;
                  end
                  if (hit_y) begin
                     pin_y_in   = use_dir[1] ^ inv_y_ff;
                     res.step_y = 1'b1;
                  end
                  active_in        = !done;
                  res.segment_done = done;
               end
            end
            CMD_STOP: begin
               rd_in     = '0;
               wr_in     = '0;
               active_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
      res.dir_x_level = pin_x_in;
      res.dir_y_level = pin_y_in;
      res.busy_res    = active_in || (rd_in != wr_in);
      res.queue_full  = (ptr_next(wr_in) == rd_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff      <= '0;
         wr_ff      <= '0;
         active_ff  <= 1'b0;
         act_sx_ff  <= '0;
         act_sy_ff  <= '0;
         act_dur_ff <= '0;
         act_dir_ff <= '0;
         elapsed_ff <= '0;
         err_x_ff   <= '0;
         err_y_ff   <= '0;
         pin_x_ff   <= 1'b0;
         pin_y_ff   <= 1'b0;
      end else begin
         rd_ff      <= rd_in;
         wr_ff      <= wr_in;
         active_ff  <= active_in;
         act_sx_ff  <= act_sx_in;
         act_sy_ff  <= act_sy_in;
         act_dur_ff <= act_dur_in;
         act_dir_ff <= act_dir_in;
         elapsed_ff <= elapsed_in;
         err_x_ff   <= err_x_in;
         err_y_ff   <= err_y_in;
         pin_x_ff   <= pin_x_in;
         pin_y_ff   <= pin_y_in;
      end
   end

   // The memory reads at the next read pointer, so the head is ready for the
   // following item, including one that pops right after a push.
   tdda_queue_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(ENTRY_W), .ADDR_W(PTR_W)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_in),
      .head    (head)
   );

   tdda_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (acc),
      .push_data (res),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_accepted     = out_data.accepted;
   assign rsp_step_x       = out_data.step_x;
   assign rsp_step_y       = out_data.step_y;
   assign rsp_dir_x_level  = out_data.dir_x_level;
   assign rsp_dir_y_level  = out_data.dir_y_level;
   assign rsp_segment_done = out_data.segment_done;
   assign rsp_busy_res     = out_data.busy_res;
   assign rsp_queue_full   = out_data.queue_full;

   // A segment pushed into an empty queue is at the head in the next cycle.
   a_head_bypass: assert property (@(posedge clock) disable iff (reset)
      (wr_en && is_empty) |=> (head == $past(wr_data)))
      else $error("queue head does not show the segment just pushed");

   // The tick counter never passes the active segment's duration.
   a_elapsed_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (elapsed_ff < act_dur_ff))
      else $error("active segment ran past its duration");

   // Every accepted item leaves a result waiting on the output.
   a_result_present: assert property (@(posedge clock) disable iff (reset)
      acc |=> rsp_valid)
      else $error("accepted item left no result");

   // A pop only happens from a queue that holds at least one segment.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (acc && (cmd == CMD_TICK) && !active_ff && (rd_in != rd_ff)) |-> !is_empty)
      else $error("segment popped from an empty queue");

endmodule

`default_nettype wire

/* sv/tdda_queue_mem.sv */
// Segment queue storage: one synchronous memory with a registered read and a
// write-to-read bypass, so the entry at the read pointer is always on hand.
// Depends on nothing but its parameters.
`default_nettype none

module tdda_queue_mem #(
   parameter int DEPTH   = 16,
   parameter int WIDTH   = 74,
   parameter int ADDR_W  = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  head
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] byp_data_ff;
   logic             byp_ff;
   logic             byp_in;

   // A write to the address being read returns the old word, so the new
   // word is carried around the memory in that case.
   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff  <= mem_ff[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign head = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

`default_nettype wire

/* sv/tdda_axis.sv */
// One axis of the DDA: adds the step count to the error accumulator and, when
// the sum reaches the duration, subtracts it and flags a step.
// Depends on nothing but its parameters.
`default_nettype none

module tdda_axis #(
   parameter int CB    = 24,
   parameter int ERR_W = 49
) (
   input  wire logic [ERR_W-1:0] err_base,
   input  wire logic [CB-1:0]    steps,
   input  wire logic [CB-1:0]    duration,
   output logic      [ERR_W-1:0] err_next,
   output logic                  step
);

   logic [ERR_W-1:0] sum;
   logic [ERR_W:0]   diff;

   always_comb begin
      sum      = err_base + {{(ERR_W-CB){1'b0}}, steps};
      diff     = {1'b0, sum} - {{(ERR_W+1-CB){1'b0}}, duration};
      step     = !diff[ERR_W];
      err_next = step ? diff[ERR_W-1:0] : sum;
   end

endmodule

`default_nettype wire

/* sv/tdda_rsp_buf.sv */
// Two-entry result buffer between the step logic and the result channel.
// Depends on tdda_pkg for the result item type.
`default_nettype none

module tdda_rsp_buf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tdda_pkg::rsp_type push_data,
   output logic                   full,
   output logic                   out_valid,
   input  wire logic              out_stall,
   output tdda_pkg::rsp_type      out_data
);

   import tdda_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_idx_ff;
   logic       rd_idx_ff;
   logic [1:0] cnt_ff;
   logic       pop;

   assign out_valid = (cnt_ff != 2'd0);
   assign full      = (cnt_ff == 2'd2);
   assign out_data  = slot_ff[rd_idx_ff];
   assign pop       = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_idx_ff <= !wr_idx_ff;
         end
         if (pop) begin
            rd_idx_ff <= !rd_idx_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

/* test/two_axis_dda_step_generator_tb.sv */
// Self-checking testbench for the two-axis DDA step generator.
// Depends on tdda_pkg and the two_axis_dda_step_generator RTL; needs no files.
// Commands go in through a queue-fed driver, and a monitor checks every status item.
module two_axis_dda_step_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tdda_pkg::*;

   localparam int QDEPTH = 16;
   localparam int CBITS = 24;
   localparam int PTR_BITS = $clog2(QDEPTH);
   localparam int ACC_BITS = 2 * CBITS + 1;
   localparam int PHASE_ITEMS = 346;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;

   // Code 3 has no meaning in the block. It must still answer with a status item.
   localparam logic [1:0] CMD_UNASSIGNED = 2'd3;

   typedef struct {
      logic [1:0]       command;
      logic [CBITS-1:0] steps_x;
      logic [CBITS-1:0] steps_y;
      logic             dir_x;
      logic             dir_y;
      logic [CBITS-1:0] seg_ticks;
   } cmd_item_type;

   // Clock, reset and every input of the block start at known values.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [1:0]       req_command = CMD_TICK;
   logic [CBITS-1:0] req_steps_x = '0;
   logic [CBITS-1:0] req_steps_y = '0;
   logic             req_dir_x = 1'b0;
   logic             req_dir_y = 1'b0;
   logic [CBITS-1:0] req_segment_ticks = '0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_accepted;
   logic rsp_step_x;
   logic rsp_step_y;
   logic rsp_dir_x_level;
   logic rsp_dir_y_level;
   logic rsp_segment_done;
   logic rsp_busy_res;
   logic rsp_queue_full;

   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   two_axis_dda_step_generator #(
      .QUEUE_DEPTH(QDEPTH),
      .COUNT_BITS (CBITS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_steps_x      (req_steps_x),
      .req_steps_y      (req_steps_y),
      .req_dir_x        (req_dir_x),
      .req_dir_y        (req_dir_y),
      .req_segment_ticks(req_segment_ticks),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_step_x       (rsp_step_x),
      .rsp_step_y       (rsp_step_y),
      .rsp_dir_x_level  (rsp_dir_x_level),
      .rsp_dir_y_level  (rsp_dir_y_level),
      .rsp_segment_done (rsp_segment_done),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_queue_full   (rsp_queue_full),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Shadow of the stepper state. It is advanced once per accepted item,
   // at the edge where the block itself takes the item.
   // ------------------------------------------------------------------
   logic [CBITS-1:0]    seg_steps_x [QDEPTH] = '{default: '0};
   logic [CBITS-1:0]    seg_steps_y [QDEPTH] = '{default: '0};
   logic [CBITS-1:0]    seg_length  [QDEPTH] = '{default: '0};
   logic [1:0]          seg_dirs    [QDEPTH] = '{default: '0};
   logic [PTR_BITS-1:0] pop_ptr = '0;
   logic [PTR_BITS-1:0] push_ptr = '0;
   logic                moving = 1'b0;
   logic [CBITS-1:0]    cur_steps_x = '0;
   logic [CBITS-1:0]    cur_steps_y = '0;
   logic [CBITS-1:0]    cur_length = '0;
   logic [1:0]          cur_dirs = '0;
   logic [CBITS-1:0]    ticks_done = '0;
   logic [ACC_BITS-1:0] accum_x = '0;
   logic [ACC_BITS-1:0] accum_y = '0;
   logic                pin_x = 1'b0;
   logic                pin_y = 1'b0;
   logic                flip_x = 1'b0;
   logic                flip_y = 1'b0;

   // Applies one command to the shadow state and returns the status it should produce.
   function automatic rsp_type dda_advance(input cmd_item_type cmd);
      rsp_type st;
      st = '0;
      case (cmd.command)
         CMD_ENQUEUE: begin
            // A zero duration or a full ring is refused and leaves everything alone.
            if (cmd.seg_ticks != '0 && PTR_BITS'(push_ptr + 1'b1) != pop_ptr) begin
               seg_steps_x[push_ptr] = cmd.steps_x;
               seg_steps_y[push_ptr] = cmd.steps_y;
               seg_length[push_ptr]  = cmd.seg_ticks;
               seg_dirs[push_ptr]    = {cmd.dir_y, cmd.dir_x};
               push_ptr = push_ptr + 1'b1;
               st.accepted = 1'b1;
            end
         end
         CMD_TICK: begin
            // An idle tick first pulls the next segment, and starts its DDA from zero.
            if (!moving && pop_ptr != push_ptr) begin
               cur_steps_x = seg_steps_x[pop_ptr];
               cur_steps_y = seg_steps_y[pop_ptr];
               cur_length  = seg_length[pop_ptr];
               cur_dirs    = seg_dirs[pop_ptr];
               pop_ptr     = pop_ptr + 1'b1;
               ticks_done  = '0;
               accum_x     = '0;
               accum_y     = '0;
               moving      = 1'b1;
            end
            if (moving) begin
               ticks_done = ticks_done + 1'b1;
               // At most one pulse per axis and tick; any surplus stays in the accumulator.
               accum_x = accum_x + cur_steps_x;
               if (accum_x >= cur_length) begin
                  accum_x = accum_x - cur_length;
                  pin_x = cur_dirs[0] ^ flip_x;
                  st.step_x = 1'b1;
               end
               accum_y = accum_y + cur_steps_y;
               if (accum_y >= cur_length) begin
                  accum_y = accum_y - cur_length;
                  pin_y = cur_dirs[1] ^ flip_y;
                  st.step_y = 1'b1;
               end
               if (ticks_done >= cur_length) begin
                  moving = 1'b0;
                  st.segment_done = 1'b1;
               end
            end
         end
         CMD_STOP: begin
            pop_ptr  = '0;
            push_ptr = '0;
            moving   = 1'b0;
         end
         default: ;
      endcase
      st.dir_x_level = pin_x;
      st.dir_y_level = pin_y;
      st.busy_res    = moving || (pop_ptr != push_ptr);
      st.queue_full  = PTR_BITS'(push_ptr + 1'b1) == pop_ptr;
      return st;
   endfunction

   // ------------------------------------------------------------------
   // Bookkeeping shared by the driver, the monitor and the sequence.
   // ------------------------------------------------------------------
   cmd_item_type pending_cmds[$];
   rsp_type      expected_status[$];
   int           fail_count = 0;
   int           cycle_count = 0;

   // Idle limits per item, set per phase. A limit of zero gives back-to-back traffic.
   int req_gap_max = 0;
   int rsp_wait_max = 0;
   // A nonzero value asks the receiver for one long hold-off of that many cycles.
   int hold_request = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (fail_count < 100)
         $display("[cycle %0d] mismatch on %s: got %0d, expected %0d",
                  cycle_count, what, got, want);
      fail_count++;
   endtask

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[cycle %0d] timeout with %0d items pending and %0d status items due",
                  cycle_count, pending_cmds.size(), expected_status.size());
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Driver. The rising edge records an accepted item and predicts its
   // status. The falling edge presents the next item after a random gap.
   // ------------------------------------------------------------------
   cmd_item_type cur_cmd;
   logic         offering = 1'b0;
   logic         req_taken = 1'b0;
   int           req_gap = 0;

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_status.push_back(dda_advance(cur_cmd));
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            offering = 1'b0;
            req_gap = $urandom_range(0, req_gap_max);
         end
         if (!offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_cmds.size() != 0) begin
               cur_cmd = pending_cmds.pop_front();
               offering = 1'b1;
               req_command       <= cur_cmd.command;
               req_steps_x       <= cur_cmd.steps_x;
               req_steps_y       <= cur_cmd.steps_y;
               req_dir_x         <= cur_cmd.dir_x;
               req_dir_y         <= cur_cmd.dir_y;
               req_segment_ticks <= cur_cmd.seg_ticks;
            end
         end
         // One assignment per edge, so a valid that stays high is never dropped.
         req_valid <= offering;
      end
   end

   // ------------------------------------------------------------------
   // Receiver. After each status item it stalls for a random number of
   // cycles. A long hold-off on request lets the block fill up and push
   // back on its input.
   // ------------------------------------------------------------------
   logic rsp_taken = 1'b0;
   int   rsp_wait = 0;
   int   hold_left = 0;

   always @(negedge clock) begin
      if (!reset) begin
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rsp_wait = $urandom_range(0, rsp_wait_max);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor. Every accepted status item is compared, field by field,
   // with the oldest prediction.
   // ------------------------------------------------------------------
   string status_field[8] = '{"queue_full", "busy_res", "segment_done", "dir_y_level",
                              "dir_x_level", "step_y", "step_x", "accepted"};

   always @(posedge clock) begin : status_monitor
      rsp_type seen;
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_taken = 1'b1;
         seen = {rsp_accepted, rsp_step_x, rsp_step_y, rsp_dir_x_level, rsp_dir_y_level,
                 rsp_segment_done, rsp_busy_res, rsp_queue_full};
         if (expected_status.size() == 0) begin
            report_mismatch("status item with none due", seen, 0);
         end else begin
            want = expected_status.pop_front();
            for (int i = 0; i < 8; i++)
               if (seen[i] !== want[i]) report_mismatch(status_field[i], seen[i], want[i]);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence helpers.
   // ------------------------------------------------------------------
   task automatic queue_cmd(input logic [1:0] command, input logic [CBITS-1:0] sx,
                            input logic [CBITS-1:0] sy, input logic dx, input logic dy,
                            input logic [CBITS-1:0] ticks);
      cmd_item_type cmd;
      cmd = '{command, sx, sy, dx, dy, ticks};
      pending_cmds.push_back(cmd);
   endtask

   // Waits until every item is taken and every status item has come back.
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || offering || expected_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write, then a read back of the same register. The block is idle here,
   // so the shadow inversion setting can follow the write at once.
   task automatic csr_write(input logic reg_idx, input logic value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {reg_idx, 2'b00};
      pwdata  = {31'b0, value};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_idx == REG_INVERT_X) flip_x = value;
      else flip_y = value;
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== {31'b0, value}) report_mismatch("register read back", prdata, value);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      // Hand back on a rising edge so later queue pushes never meet the driver.
      @(posedge clock);
   endtask

   function automatic logic [CBITS-1:0] draw_steps();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return CBITS'($urandom);
         default: return CBITS'($urandom_range(0, 12));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Main sequence: reset, a short directed part, then random phases that
   // each set the inversion setting and idle pattern anew.
   // ------------------------------------------------------------------
   initial begin
      logic [CBITS-1:0] sx;
      logic [CBITS-1:0] sy;
      logic [CBITS-1:0] ticks;
      logic             dx;
      logic             dy;
      int               pick;
      int               enq_pct;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_write(REG_INVERT_X, 1'b0);
      csr_write(REG_INVERT_Y, 1'b0);

      // Directed part. A tick with nothing queued must change nothing, and the
      // unassigned code only reports status.
      queue_cmd(CMD_TICK, '0, '0, 1'b0, 1'b0, '0);
      queue_cmd(CMD_UNASSIGNED, '1, '1, 1'b1, 1'b1, '1);
      // A zero duration is refused.
      queue_cmd(CMD_ENQUEUE, 24'd5, 24'd5, 1'b1, 1'b1, '0);
      // Far more X steps than ticks: one pulse, and the surplus stays behind.
      queue_cmd(CMD_ENQUEUE, '1, '0, 1'b1, 1'b0, 24'd1);
      queue_cmd(CMD_TICK, '0, '0, 1'b0, 1'b0, '0);
      // The longest segment starts, and a stop later drops it in mid-move.
      queue_cmd(CMD_ENQUEUE, '0, '1, 1'b0, 1'b1, '1);
      queue_cmd(CMD_TICK, '0, '0, 1'b0, 1'b0, '0);
      queue_cmd(CMD_STOP, '0, '0, 1'b0, 1'b0, '0);
      // Fill the ring to its limit. The last push is refused.
      for (int i = 0; i < QDEPTH; i++)
         queue_cmd(CMD_ENQUEUE, CBITS'($urandom_range(0, 9)), CBITS'($urandom_range(0, 9)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   CBITS'($urandom_range(1, 4)));
      wait_drained();

      // Random phases. Phase 1 sends back to back and holds the receiver off for a
      // long stretch, so the result buffer fills and the input stalls.
      for (int p = 0; p < 5; p++) begin
         csr_write(REG_INVERT_X, 1'(p % 2 == 0));
         csr_write(REG_INVERT_Y, 1'(p == 1 || p == 2 || p == 4));
         req_gap_max  = (p % 2 == 0) ? 19 : 0;
         rsp_wait_max = (p == 2 || p == 3) ? 0 : 19;
         enq_pct = 30 + 6 * p;
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            dx = 1'($urandom_range(0, 1));
            dy = 1'($urandom_range(0, 1));
            // Mostly short segments so they finish; a few run until a stop.
            case ($urandom_range(0, 19))
               0: ticks = CBITS'($urandom);
               1: ticks = '1;
               2: ticks = '0;
               default: ticks = CBITS'($urandom_range(1, 6));
            endcase
            sx = draw_steps();
            sy = draw_steps();
            if (pick < enq_pct) queue_cmd(CMD_ENQUEUE, sx, sy, dx, dy, ticks);
            else if (pick < 95) queue_cmd(CMD_TICK, sx, sy, dx, dy, ticks);
            else if (pick < 98) queue_cmd(CMD_STOP, sx, sy, dx, dy, ticks);
            else queue_cmd(CMD_UNASSIGNED, sx, sy, dx, dy, ticks);
         end
         if (p == 1) hold_request = HOLD_CYCLES;
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
